### rtl/core/tiled_window_vertical_scroll_macros.svh
// Assertion macros for the tiled window vertical scroll block.
// Used by the top level; expects clk and arst_n in scope.
`ifndef TILED_WINDOW_VERTICAL_SCROLL_MACROS_SVH
`define TILED_WINDOW_VERTICAL_SCROLL_MACROS_SVH

// same-cycle implication, checked out of reset
`define TWVS_HOLDS(name, pre, post, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (pre) |-> (post)) \
		else $error(msg);

// next-cycle implication, checked out of reset
`define TWVS_LEADS(name, pre, post, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (pre) |=> (post)) \
		else $error(msg);

`endif

### rtl/core/twvs_pkg.sv
// Shared types, constants and window size function for the tiled window scroll block.
// No dependencies.
package twvs_pkg;

	localparam int MAX_WORDS = 4096;
	localparam int WORDS_PER_TILE = 8;
	localparam int TILE_LIMIT = 512;
	localparam int TILE_CAP = (MAX_WORDS / WORDS_PER_TILE < TILE_LIMIT) ?
		MAX_WORDS / WORDS_PER_TILE : TILE_LIMIT;
	localparam int WIN_WORDS = TILE_CAP * WORDS_PER_TILE;
	localparam int ADDR_W = $clog2(WIN_WORDS);
	localparam int SIZE_W = $clog2(WIN_WORDS + 1);
	localparam int IDX_W = 12;
	localparam int CMP_W = (SIZE_W > IDX_W) ? SIZE_W : IDX_W;
	localparam int SRC_W = 15;
	localparam int DATA_W = 32;
	localparam int CFG_W = 6;
	localparam int PADDR_W = 3;
	localparam logic [CFG_W-1:0] DIM_CAP = 6'd32;

	localparam logic [1:0] OP_WRITE = 2'd0;
	localparam logic [1:0] OP_READ = 2'd1;
	localparam logic [1:0] OP_SCROLL = 2'd2;

	localparam logic [1:0] DIR_DOWN = 2'd0;
	localparam logic [1:0] DIR_UP = 2'd1;

	localparam logic REG_WIDTH = 1'b0;
	localparam logic REG_HEIGHT = 1'b1;

	typedef struct packed {
		logic [1:0] op;
		logic [IDX_W-1:0] word_index;
		logic [DATA_W-1:0] write_data;
		logic [1:0] direction;
		logic [7:0] distance;
		logic [7:0] fill_byte;
	} req_t;

	typedef struct packed {
		logic [DATA_W-1:0] read_data;
		logic status;
	} rsp_t;

	typedef struct packed {
		logic [CFG_W-1:0] width_cl;
		logic [SIZE_W-1:0] window_words;
	} cfg_t;

	typedef struct packed {
		logic [ADDR_W-1:0] idx;
		logic [7:0] rows;
		logic [CFG_W-1:0] width_cl;
		logic [SIZE_W-1:0] size;
		logic up;
	} scan_t;

	typedef struct packed {
		logic [ADDR_W-1:0] rd_addr;
		logic [ADDR_W-1:0] wr_addr;
		logic in_range;
	} scan_addr_t;

	typedef enum logic [3:0] {
		ST_IDLE = 4'b0001,
		ST_READ = 4'b0010,
		ST_SCROLL = 4'b0100,
		ST_DRAIN = 4'b1000
	} state_t;

	function automatic logic [CFG_W-1:0] clamp_dim(input logic [CFG_W-1:0] v);
		return (v > DIM_CAP) ? DIM_CAP : v;
	endfunction

	function automatic logic [SIZE_W-1:0] calc_window_words(input logic [CFG_W-1:0] w,
			input logic [CFG_W-1:0] h);
		logic [2*CFG_W-1:0] tiles;
		tiles = clamp_dim(w) * clamp_dim(h);
		if (tiles > (2*CFG_W)'(TILE_CAP)) begin
			tiles = (2*CFG_W)'(TILE_CAP);
		end
		return SIZE_W'({tiles, 3'b000});
	endfunction

endpackage

### rtl/core/twvs_ram.sv
// Generic single-write, single-read synchronous RAM with registered read data.
// No dependencies.
module twvs_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 4096
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

### rtl/core/twvs_cfg.sv
// Configuration registers (window width and height) behind the APB-style port.
// Depends on twvs_pkg.
module twvs_cfg (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [twvs_pkg::PADDR_W-1:0]  paddr,
	input  logic [31:0]                   pwdata,
	output logic [31:0]                   prdata,
	output twvs_pkg::cfg_t                cfg
);

	import twvs_pkg::*;

	logic [CFG_W-1:0] width_q;
	logic [CFG_W-1:0] height_q;
	logic             wr_en;
	logic             reg_sel;

	assign wr_en = psel && penable && pwrite;
	assign reg_sel = paddr[2];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q <= CFG_W'(1);
			height_q <= CFG_W'(1);
		end else if (wr_en) begin
			case (reg_sel)
				REG_WIDTH: width_q <= pwdata[CFG_W-1:0];
				REG_HEIGHT: height_q <= pwdata[CFG_W-1:0];
				default: width_q <= width_q;
			endcase
		end
	end

	always_comb begin
		case (reg_sel)
			REG_WIDTH: prdata = 32'(width_q);
			REG_HEIGHT: prdata = 32'(height_q);
			default: prdata = '0;
		endcase
	end

	assign cfg.width_cl = clamp_dim(width_q);
	assign cfg.window_words = calc_window_words(width_q, height_q);

endmodule

### rtl/core/twvs_agen.sv
// Scroll address generator: source and destination word for one scan step.
// Depends on twvs_pkg.
module twvs_agen (
	input  twvs_pkg::scan_t      scan,
	output twvs_pkg::scan_addr_t addr
);

	import twvs_pkg::*;

	logic [8:0]       d;
	logic [11:0]      off;
	logic [SRC_W-1:0] base;
	logic [SRC_W-1:0] src;
	logic [SRC_W-1:0] last;

	always_comb begin
		d = 9'(scan.rows) + 9'(scan.idx[2:0]);
		off = scan.width_cl * d[8:3];
		base = SRC_W'(scan.idx) & ~SRC_W'(3'd7);
		src = base + SRC_W'({off, 3'b000}) + SRC_W'(d[2:0]);
		last = SRC_W'(scan.size) - SRC_W'(1);
		addr.in_range = src < SRC_W'(scan.size);
		addr.rd_addr = scan.up ? ADDR_W'(last - src) : ADDR_W'(src);
		addr.wr_addr = scan.up ? ADDR_W'(last - SRC_W'(scan.idx)) : scan.idx;
	end

endmodule

### rtl/core/tiled_window_vertical_scroll.sv
// Pixel buffer of one tiled 4bpp window with word access and in-place vertical scroll.
// Depends on twvs_pkg, twvs_cfg, twvs_agen, twvs_ram and the assertion macro header.
//
// The buffer sits in one synchronous RAM with one write and one read port. A word write
// goes to the RAM when accepted; a read inside the window passes through ST_READ, which
// loads the registered RAM read data. Every result is held in an output register; while
// it is stalled, the next item is held off. A scroll walks every word of the window
// through the RAM, one word per cycle: each cycle reads a source word and writes the
// word read in the cycle before.
// Window words not yet written hold unknown data, and so do scroll results built from them.
`include "tiled_window_vertical_scroll_macros.svh"

module tiled_window_vertical_scroll (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         psel,
	input  logic                         penable,
	input  logic                         pwrite,
	input  logic [twvs_pkg::PADDR_W-1:0] paddr,
	input  logic [31:0]                  pwdata,
	output logic [31:0]                  prdata,
	output logic                         pready,
	input  logic                         req_valid,
	output logic                         req_stall,
	input  twvs_pkg::req_t               req,
	output logic                         rsp_valid,
	input  logic                         rsp_stall,
	output twvs_pkg::rsp_t               rsp
);

	import twvs_pkg::*;

	cfg_t             cfg;
	state_t           state_q;
	state_t           state_d;
	logic             accept;
	logic             idx_ok;
	logic             scroll_go;
	logic             scan_last;
	logic [ADDR_W-1:0] scan_idx_q;
	logic [7:0]       dist_q;
	logic             up_q;
	logic [7:0]       fill_q;
	scan_t            scan;
	scan_addr_t       saddr;
	logic             valid_s1;
	logic [ADDR_W-1:0] wr_addr_s1;
	logic             in_range_s1;
	logic             ram_we;
	logic [ADDR_W-1:0] ram_waddr;
	logic [DATA_W-1:0] ram_wdata;
	logic             ram_re;
	logic [ADDR_W-1:0] ram_raddr;
	logic [DATA_W-1:0] ram_rdata;
	logic             out_load;
	rsp_t             out_d;
	logic             out_valid_q;
	rsp_t             out_q;

	assign pready = 1'b1;

	twvs_cfg u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.cfg     (cfg)
	);

	assign req_stall = (state_q != ST_IDLE) || (out_valid_q && rsp_stall);
	assign accept = req_valid && !req_stall;
	assign idx_ok = CMP_W'(req.word_index) < CMP_W'(cfg.window_words);
	assign scroll_go = (cfg.window_words != '0) &&
		(req.direction == DIR_DOWN || req.direction == DIR_UP);

	assign scan.idx = scan_idx_q;
	assign scan.rows = dist_q;
	assign scan.width_cl = cfg.width_cl;
	assign scan.size = cfg.window_words;
	assign scan.up = up_q;
	assign scan_last = SIZE_W'(scan_idx_q) == (cfg.window_words - SIZE_W'(1));

	twvs_agen u_agen (
		.scan (scan),
		.addr (saddr)
	);

	always_comb begin
		state_d = state_q;
		out_load = 1'b0;
		out_d = '0;
		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					case (req.op)
						OP_WRITE: begin
							out_load = 1'b1;
							out_d.status = !idx_ok;
						end
						OP_READ: begin
							if (idx_ok) begin
								state_d = ST_READ;
							end else begin
								out_load = 1'b1;
								out_d.status = 1'b1;
							end
						end
						OP_SCROLL: begin
							if (scroll_go) begin
								state_d = ST_SCROLL;
							end else begin
								out_load = 1'b1;
							end
						end
						default: out_load = 1'b1;
					endcase
				end
			end
			ST_READ: begin
				out_load = 1'b1;
				out_d.read_data = ram_rdata;
				state_d = ST_IDLE;
			end
			ST_SCROLL: begin
				if (scan_last) begin
					state_d = ST_DRAIN;
				end
			end
			ST_DRAIN: begin
				out_load = 1'b1;
				state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		ram_we = valid_s1 || (accept && req.op == OP_WRITE && idx_ok);
		ram_waddr = valid_s1 ? wr_addr_s1 : ADDR_W'(req.word_index);
		ram_wdata = valid_s1 ? (in_range_s1 ? ram_rdata : {4{fill_q}}) : req.write_data;
		ram_re = (state_q == ST_SCROLL) ? saddr.in_range :
			(accept && req.op == OP_READ && idx_ok);
		ram_raddr = (state_q == ST_SCROLL) ? saddr.rd_addr : ADDR_W'(req.word_index);
	end

	twvs_ram #(
		.WIDTH (DATA_W),
		.DEPTH (WIN_WORDS)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			valid_s1 <= 1'b0;
			scan_idx_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			valid_s1 <= state_q == ST_SCROLL;
			if (state_q == ST_SCROLL) begin
				scan_idx_q <= scan_idx_q + ADDR_W'(1);
			end else begin
				scan_idx_q <= '0;
			end
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		wr_addr_s1 <= saddr.wr_addr;
		in_range_s1 <= saddr.in_range;
		if (accept) begin
			dist_q <= req.distance;
			up_q <= req.direction == DIR_UP;
			fill_q <= req.fill_byte;
		end
		if (out_load) begin
			out_q <= out_d;
		end
	end

	assign rsp_valid = out_valid_q;
	assign rsp = out_q;

	`TWVS_HOLDS(a_no_result_overrun, out_load, !(out_valid_q && rsp_stall), "result dropped")
	`TWVS_HOLDS(a_no_write_clash, valid_s1, !accept, "transfer during scroll write-back")
	`TWVS_HOLDS(a_no_rw_overlap, valid_s1 && state_q == ST_SCROLL && saddr.in_range, saddr.rd_addr != wr_addr_s1, "scroll read hits pending write")
	`TWVS_LEADS(a_read_follows, accept && req.op == OP_READ && idx_ok, state_q == ST_READ, "read not issued")

endmodule
